// ===== src/i2c_bit_bang_master_macros.svh =====
// assertion helpers for the i2c bit-bang master checker
`ifndef I2C_BIT_BANG_MASTER_MACROS_SVH
`define I2C_BIT_BANG_MASTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("i2c bit-bang master check failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("i2c bit-bang master check failed");

`endif

// ===== src/i2cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbb_pkg
// shared types, codes and helpers of the i2c bit-bang master
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbb_pkg;

  localparam int DlyW      = 11;  // 6 us * 255 ticks fits
  localparam int InDataW   = 16;
  localparam int OutDataW  = 16;
  localparam int OpW       = 3;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // raw op codes on the stream
  localparam logic [OpW-1:0] OP_TICK     = 3'd0;
  localparam logic [OpW-1:0] OP_START    = 3'd1;
  localparam logic [OpW-1:0] OP_STOP     = 3'd2;
  localparam logic [OpW-1:0] OP_WRITE    = 3'd3;
  localparam logic [OpW-1:0] OP_READ     = 3'd4;
  localparam logic [OpW-1:0] OP_WAIT_ACK = 3'd5;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  localparam logic [7:0] TICKS_PER_US_RST = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

  // delay lengths in microseconds
  localparam logic [2:0] US_1 = 3'd1;
  localparam logic [2:0] US_2 = 3'd2;
  localparam logic [2:0] US_5 = 3'd5;
  localparam logic [2:0] US_6 = 3'd6;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_START,
    KIND_STOP,
    KIND_WRITE,
    KIND_READ,
    KIND_WAIT_ACK,
    KIND_NONE
  } kind_e;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_SA_A,
    PH_SA_B,
    PH_ST_A,
    PH_ST_B,
    PH_WA_A,
    PH_WA_B,
    PH_WA_POLL,
    PH_WA_HIGH,
    PH_WA_END,
    PH_WR_HI,
    PH_WR_NEXT,
    PH_WR_TAIL,
    PH_RD_LO,
    PH_RD_WAIT,
    PH_RD_NEXT,
    PH_AK_HI,
    PH_AK_END
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_level;
    logic       scl_level;
  } entry_t;

  // microseconds times ticks per microsecond, zero rate counts as one
  function automatic logic [DlyW-1:0] us_ticks(input logic [2:0] us, input logic [7:0] tpu);
    logic [7:0] t;
    t = (tpu == 8'd0) ? 8'd1 : tpu;
    return DlyW'(us) * DlyW'(t);
  endfunction

endpackage

`default_nettype wire

// ===== src/i2cbb_front.sv =====
// ----------------------------------------------------------------------------
// i2cbb_front
// input side: unpacks stream beats and classifies them into queue entries
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_front (
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [i2cbb_pkg::InDataW-1:0] s_axis_tdata_i,
  input  wire logic [i2cbb_pkg::OpW-1:0]   s_axis_tuser_i,
  input  wire logic                        full_i,
  output logic                             push_o,
  output i2cbb_pkg::entry_t                entry_o
);
  import i2cbb_pkg::*;

  kind_e kind;

  always_comb begin
    unique case (s_axis_tuser_i)
      OP_TICK:     kind = KIND_TICK;
      OP_START:    kind = KIND_START;
      OP_STOP:     kind = KIND_STOP;
      OP_WRITE:    kind = KIND_WRITE;
      OP_READ:     kind = KIND_READ;
      OP_WAIT_ACK: kind = KIND_WAIT_ACK;
      default:     kind = KIND_NONE;
    endcase
  end

  assign s_axis_tready_o    = !full_i;
  assign push_o             = s_axis_tvalid_i && !full_i;
  assign entry_o.kind       = kind;
  assign entry_o.data_byte  = s_axis_tdata_i[7:0];
  assign entry_o.send_ack   = s_axis_tdata_i[8];
  assign entry_o.sda_level  = s_axis_tdata_i[9];
  assign entry_o.scl_level  = s_axis_tdata_i[10];

endmodule

`default_nettype wire

// ===== src/i2cbb_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cbb_fifo
// short queue of classified items between front and sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  i2cbb_pkg::entry_t      entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output i2cbb_pkg::entry_t      entry_o
);
  import i2cbb_pkg::*;

  entry_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2cbb_seq.sv =====
// ----------------------------------------------------------------------------
// i2cbb_seq
// pin sequencer: one queue entry per step, result held in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [7:0]                   cfg_wdata_i,
  input  wire logic                         empty_i,
  input  i2cbb_pkg::entry_t                 entry_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [i2cbb_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import i2cbb_pkg::*;

  logic [7:0]      tpu_q, ack_to_q;
  phase_e          phase_q, phase_d;
  logic [DlyW-1:0] delay_q, delay_d, dec_cnt;
  logic [3:0]      bit_q, bit_d, bit_inc;
  logic [7:0]      shift_q, shift_d;
  logic [7:0]      to_q, to_d;
  logic            scl_q, scl_d, sda_q, sda_d, fail_q, fail_d;
  logic [7:0]      rd_q, rd_d;
  logic            ack_sel_q, ack_sel_d;
  logic            step, tick, timed, expire, done;
  logic            out_vld_q;
  logic [OutDataW-1:0] out_q;

  // a step runs whenever an item waits and the result slot can take it
  assign step    = !empty_i && (!out_vld_q || m_axis_tready_i);
  assign pop_o   = step;
  assign tick    = (entry_i.kind == KIND_TICK);
  assign dec_cnt = delay_q - DlyW'(delay_q != '0);
  assign timed   = (phase_q != PH_IDLE) && (phase_q != PH_RD_WAIT) && (phase_q != PH_WA_POLL);
  assign expire  = tick && timed && (dec_cnt == '0);
  assign bit_inc = bit_q + 4'd1;
  assign done    = expire && (phase_d == PH_IDLE);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step) begin
      if (tick) begin
        if (phase_q == PH_RD_WAIT) begin
          if (entry_i.scl_level) phase_d = PH_RD_NEXT;
        end else if (phase_q == PH_WA_POLL) begin
          phase_d = entry_i.sda_level ? PH_WA_HIGH : PH_WA_END;
        end else if (expire) begin
          unique case (phase_q)
            PH_SA_A:    phase_d = PH_SA_B;
            PH_ST_A:    phase_d = PH_ST_B;
            PH_WA_A:    phase_d = PH_WA_B;
            PH_WA_B:    phase_d = PH_WA_POLL;
            PH_WA_HIGH: phase_d = fail_q ? PH_ST_A : PH_WA_POLL;
            PH_WR_HI:   phase_d = PH_WR_NEXT;
            PH_WR_NEXT: phase_d = bit_inc[3] ? PH_WR_TAIL : PH_WR_HI;
            PH_WR_TAIL: phase_d = PH_AK_HI;
            PH_RD_LO:   phase_d = PH_RD_WAIT;
            PH_RD_NEXT: phase_d = bit_inc[3] ? PH_AK_HI : PH_RD_LO;
            PH_AK_HI:   phase_d = PH_AK_END;
            default:    phase_d = PH_IDLE;
          endcase
        end
      end else if (phase_q == PH_IDLE) begin
        unique case (entry_i.kind)
          KIND_START:    phase_d = PH_SA_A;
          KIND_STOP:     phase_d = PH_ST_A;
          KIND_WRITE:    phase_d = PH_WR_HI;
          KIND_READ:     phase_d = PH_RD_LO;
          KIND_WAIT_ACK: phase_d = PH_WA_A;
          default:       phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // datapath and pin requests
  always_comb begin
    delay_d   = delay_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    to_d      = to_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    fail_d    = fail_q;
    rd_d      = rd_q;
    ack_sel_d = ack_sel_q;
    if (step) begin
      if (tick) begin
        if (phase_q == PH_RD_WAIT) begin
          if (entry_i.scl_level) begin
            shift_d = {shift_q[6:0], entry_i.sda_level};
            delay_d = us_ticks(US_1, tpu_q);
          end
        end else if (phase_q == PH_WA_POLL) begin
          delay_d = us_ticks(US_1, tpu_q);
          if (!entry_i.sda_level) begin
            scl_d = 1'b1;
          end else if (to_q >= ack_to_q) begin
            fail_d = 1'b1;
          end else begin
            to_d = to_q + 8'd1;
          end
        end else if (phase_q != PH_IDLE) begin
          delay_d = dec_cnt;
          if (expire) begin
            unique case (phase_q)
              PH_SA_A: begin
                sda_d   = 1'b1;
                delay_d = us_ticks(US_5, tpu_q);
              end
              PH_ST_A: begin
                sda_d   = 1'b0;
                delay_d = us_ticks(US_6, tpu_q);
              end
              PH_WA_A: begin
                scl_d   = 1'b0;
                delay_d = us_ticks(US_1, tpu_q);
              end
              PH_WA_HIGH: begin
                // timed out: run a stop
                if (fail_q) begin
                  scl_d   = 1'b0;
                  sda_d   = 1'b1;
                  delay_d = us_ticks(US_6, tpu_q);
                end
              end
              PH_WR_HI: begin
                scl_d   = 1'b0;
                delay_d = us_ticks(US_2, tpu_q);
              end
              PH_WR_NEXT: begin
                bit_d = bit_inc;
                scl_d = 1'b1;
                if (!bit_inc[3]) begin
                  sda_d   = !shift_q[7];
                  shift_d = {shift_q[6:0], 1'b0};
                  delay_d = us_ticks(US_1, tpu_q);
                end else begin
                  delay_d = us_ticks(US_2, tpu_q);
                end
              end
              PH_WR_TAIL: begin
                scl_d   = 1'b1;
                sda_d   = 1'b0;
                delay_d = us_ticks(US_2, tpu_q);
              end
              PH_RD_LO: scl_d = 1'b0;
              PH_RD_NEXT: begin
                bit_d   = bit_inc;
                scl_d   = 1'b1;
                delay_d = us_ticks(US_2, tpu_q);
                if (bit_inc[3]) begin
                  rd_d  = shift_q;
                  sda_d = ack_sel_q;
                end
              end
              PH_AK_HI: begin
                scl_d   = 1'b0;
                delay_d = us_ticks(US_5, tpu_q);
              end
              PH_AK_END: scl_d = 1'b1;
              default: ;
            endcase
          end
        end
      end else if (phase_q == PH_IDLE) begin
        unique case (entry_i.kind)
          KIND_START: begin
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            delay_d = us_ticks(US_5, tpu_q);
          end
          KIND_STOP: begin
            scl_d   = 1'b0;
            sda_d   = 1'b1;
            delay_d = us_ticks(US_6, tpu_q);
          end
          KIND_WRITE: begin
            bit_d   = 4'd0;
            scl_d   = 1'b1;
            sda_d   = !entry_i.data_byte[7];
            shift_d = {entry_i.data_byte[6:0], 1'b0};
            delay_d = us_ticks(US_1, tpu_q);
          end
          KIND_READ: begin
            bit_d     = 4'd0;
            shift_d   = 8'd0;
            ack_sel_d = entry_i.send_ack;
            sda_d     = 1'b0;
            scl_d     = 1'b1;
            delay_d   = us_ticks(US_2, tpu_q);
          end
          KIND_WAIT_ACK: begin
            fail_d  = 1'b0;
            to_d    = 8'd0;
            sda_d   = 1'b0;
            delay_d = us_ticks(US_1, tpu_q);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q     <= TICKS_PER_US_RST;
      ack_to_q  <= ACK_TIMEOUT_RST;
      phase_q   <= PH_IDLE;
      delay_q   <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      to_q      <= '0;
      scl_q     <= 1'b0;
      sda_q     <= 1'b0;
      fail_q    <= 1'b0;
      rd_q      <= '0;
      ack_sel_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TICKS_PER_US) tpu_q <= cfg_wdata_i;
        if (cfg_idx_i == CFG_ACK_TIMEOUT)  ack_to_q <= cfg_wdata_i;
      end
      phase_q   <= phase_d;
      delay_q   <= delay_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      to_q      <= to_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      fail_q    <= fail_d;
      rd_q      <= rd_d;
      ack_sel_q <= ack_sel_d;
      if (step) out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= {3'b000, fail_d, rd_d, done, (phase_d != PH_IDLE), sda_d, scl_d};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

// ===== src/i2c_bit_bang_master.sv =====
// a beat accepted into the queue is stepped once the result register can take it, and that step loads its result beat
// throughput: one beat per cycle while result beats are taken, set by the single-step sequencer and result register
// while a result beat is stalled the queue fills to its two entries, then input ready drops
// reset: asynchronous, active low; pins released, phase idle, ticks_per_us 1,
// ack_timeout 250, read byte zero, queue and result register empty
// ----------------------------------------------------------------------------
// i2c_bit_bang_master
// i2c master pin sequencer driven by commands and sampled-pin ticks
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_bang_master (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: index 0 ticks_per_us, index 1 ack_timeout
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [7:0]                    cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: data_byte[7:0], send_ack[8], sda_level[9], scl_level[10], zero fill
  input  wire logic [i2cbb_pkg::InDataW-1:0] s_axis_tdata_i,
  // tuser: op[2:0]
  input  wire logic [i2cbb_pkg::OpW-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata: scl_pull_low[0], sda_pull_low[1], busy_res[2], done_res[3],
  //        read_data[11:4], ack_missing[12], zero fill
  output logic [i2cbb_pkg::OutDataW-1:0]     m_axis_tdata_o
);
  import i2cbb_pkg::*;

  entry_t push_entry, pop_entry;
  logic   push, pop, full, empty;

  // front: unpack and classify each beat
  i2cbb_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .full_i          (full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  // queue decoupling the two sides
  i2cbb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  // back: pin sequencer and result register
  i2cbb_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .empty_i         (empty),
    .entry_i         (pop_entry),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ===== src/i2cbb_checker.sv =====
// ----------------------------------------------------------------------------
// i2cbb_checker
// port-level checks on the i2c bit-bang master, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_bit_bang_master_macros.svh"

module i2cbb_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tready_o,
  input  wire logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  input  wire logic [i2cbb_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // a stalled result beat holds
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  // a finishing step leaves the sequencer idle
  `CHK_SAME(a_done_idle, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[3], !m_axis_tdata_o[2])
  // input only backs up behind a waiting result
  `CHK_SAME(a_ready_low, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o)
  // padding bits stay zero
  `CHK_SAME(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[15:13] == 3'b000)

endmodule

bind i2c_bit_bang_master i2cbb_checker u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the i2c bit-bang master: a short table of commands
// and ticks, then random command sequences over several tick rates and ack
// timeouts, every output beat checked against a cycle-free pin sequencer
// ----------------------------------------------------------------------------

module testbench;
  import i2cbb_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int NumPhases = 8;

  // op codes the block must ignore
  localparam logic [OpW-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OpW-1:0] OP_UNUSED_7 = 3'd7;

  // one input beat, fields as the block sees them
  typedef struct packed {
    logic [OpW-1:0] op;
    logic [7:0]     data_byte;
    logic           send_ack;
    logic           sda_level;
    logic           scl_level;
  } cmd_beat_t;

  // one output beat
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       missing;
  } pin_res_t;

  // directed row: beat, whether the outputs are typed in, and those outputs
  typedef struct packed {
    cmd_beat_t beat;
    logic      typed;
    pin_res_t  res;
  } dir_row_t;

  localparam pin_res_t PINS_RESET = '0;

  // ---------------------------------------------------------------------------
  // dut signals, every input known from time zero
  // ---------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = CFG_TICKS_PER_US;
  logic [7:0]          cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [OpW-1:0]      s_axis_tuser_i = OP_TICK;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  i2c_bit_bang_master uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // pin sequencer: own copy of state and registers
  // ---------------------------------------------------------------------------
  logic [7:0]  tpu = TICKS_PER_US_RST;
  logic [7:0]  ack_limit = ACK_TIMEOUT_RST;
  phase_e      ph = PH_IDLE;
  logic [15:0] dly = '0;
  logic [3:0]  bit_n = '0;
  logic [7:0]  shf = '0;
  logic [7:0]  tmo_n = '0;
  logic        scl_low = 1'b0;
  logic        sda_low = 1'b0;
  logic        fail_flag = 1'b0;
  logic [7:0]  rd_byte = '0;
  logic        ack_sel = 1'b0;

  // expected output beats, oldest first
  pin_res_t    pins_due_q[$];

  int unsigned cycle_cnt = 0;
  int          accepted_beats = 0;
  int          fail_count = 0;

  // delay load, zero rate counts as one tick per microsecond
  function automatic void us_delay(input int unsigned us);
    int unsigned t;
    t = (tpu == 8'd0) ? 1 : int'(tpu);
    dly = 16'(us * t);
  endfunction

  // put the next data bit on sda with scl held low, msb first
  function automatic void load_write_bit();
    scl_low = 1'b1;
    sda_low = ~shf[7];
    shf = {shf[6:0], 1'b0};
    us_delay(1);
    ph = PH_WR_HI;
  endfunction

  function automatic void enter_stop();
    scl_low = 1'b0;
    sda_low = 1'b1;
    us_delay(6);
    ph = PH_ST_A;
  endfunction

  // current delay has run out; returns 1 when the sequence finishes
  function automatic bit delay_expired();
    bit fin;
    fin = 1'b0;
    case (ph)
      PH_SA_A: begin
        sda_low = 1'b1; us_delay(5); ph = PH_SA_B;
      end
      PH_ST_A: begin
        sda_low = 1'b0; us_delay(6); ph = PH_ST_B;
      end
      PH_WA_A: begin
        scl_low = 1'b0; us_delay(1); ph = PH_WA_B;
      end
      PH_WA_B: ph = PH_WA_POLL;
      PH_WA_HIGH: begin
        // timed out: a stop follows before the sequence ends
        if (fail_flag) enter_stop();
        else ph = PH_WA_POLL;
      end
      PH_WR_HI: begin
        scl_low = 1'b0; us_delay(2); ph = PH_WR_NEXT;
      end
      PH_WR_NEXT: begin
        bit_n = bit_n + 4'd1;
        if (bit_n < 4'd8) begin
          load_write_bit();
        end else begin
          scl_low = 1'b1; us_delay(2); ph = PH_WR_TAIL;
        end
      end
      PH_WR_TAIL: begin
        // ack clock with sda released, ack not sampled
        scl_low = 1'b1; sda_low = 1'b0; us_delay(2); ph = PH_AK_HI;
      end
      PH_RD_LO: begin
        scl_low = 1'b0; ph = PH_RD_WAIT;
      end
      PH_RD_NEXT: begin
        bit_n = bit_n + 4'd1;
        scl_low = 1'b1;
        if (bit_n < 4'd8) begin
          us_delay(2); ph = PH_RD_LO;
        end else begin
          rd_byte = shf;
          sda_low = ack_sel;
          us_delay(2); ph = PH_AK_HI;
        end
      end
      PH_AK_HI: begin
        scl_low = 1'b0; us_delay(5); ph = PH_AK_END;
      end
      PH_AK_END: begin
        scl_low = 1'b1; ph = PH_IDLE; fin = 1'b1;
      end
      default: begin
        // end of start, stop and ack wait
        ph = PH_IDLE; fin = 1'b1;
      end
    endcase
    return fin;
  endfunction

  // advance by one accepted beat and return the pins and flags it leaves
  function automatic pin_res_t step_sequencer(input cmd_beat_t b);
    pin_res_t r;
    bit fin;
    fin = 1'b0;
    if (b.op == OP_TICK) begin
      if (ph == PH_RD_WAIT) begin
        // clock stretching: sample only once scl reads high
        if (b.scl_level) begin
          shf = {shf[6:0], b.sda_level};
          us_delay(1);
          ph = PH_RD_NEXT;
        end
      end else if (ph == PH_WA_POLL) begin
        if (!b.sda_level) begin
          scl_low = 1'b1; us_delay(1); ph = PH_WA_END;
        end else begin
          if (tmo_n >= ack_limit) fail_flag = 1'b1;
          else tmo_n = tmo_n + 8'd1;
          us_delay(1);
          ph = PH_WA_HIGH;
        end
      end else if (ph != PH_IDLE) begin
        if (dly != 16'd0) dly = dly - 16'd1;
        if (dly == 16'd0) fin = delay_expired();
      end
    end else if (ph == PH_IDLE && b.op <= OP_WAIT_ACK) begin
      case (b.op)
        OP_START: begin
          scl_low = 1'b0; sda_low = 1'b0; us_delay(5); ph = PH_SA_A;
        end
        OP_STOP: enter_stop();
        OP_WRITE: begin
          bit_n = '0; shf = b.data_byte; load_write_bit();
        end
        OP_READ: begin
          bit_n = '0; shf = '0; ack_sel = b.send_ack;
          sda_low = 1'b0; scl_low = 1'b1; us_delay(2); ph = PH_RD_LO;
        end
        default: begin
          fail_flag = 1'b0; tmo_n = '0;
          sda_low = 1'b0; us_delay(1); ph = PH_WA_A;
        end
      endcase
    end
    r.scl_low = scl_low;
    r.sda_low = sda_low;
    r.busy    = (ph != PH_IDLE);
    r.done    = fin;
    r.rd      = rd_byte;
    r.missing = fail_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // commands first, then the two unused codes
  logic [OpW-1:0] op_pool [7] = '{OP_START, OP_STOP, OP_WRITE, OP_READ, OP_WAIT_ACK,
                                  OP_UNUSED_6, OP_UNUSED_7};

  // per phase: tick rate, ack timeout, commands issued, percent of high acks
  int plan_tpu   [NumPhases] = '{1, 1, 2, 0, 1, 4, 3, 1};
  int plan_ato   [NumPhases] = '{250, 0, 1, 3, 255, 2, 7, 1};
  int plan_cmds  [NumPhases] = '{3, 3, 2, 3, 2, 1, 1, 2};
  int plan_high  [NumPhases] = '{30, 70, 60, 50, 20, 80, 60, 75};

  // directed part, run with the reset register values
  dir_row_t dir_table [25] = '{
    // tick while idle, fields at both extremes
    '{'{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, PINS_RESET},
    '{'{OP_TICK,     8'hff, 1'b1, 1'b1, 1'b1}, 1'b1, PINS_RESET},
    // unused codes do nothing
    '{'{OP_UNUSED_6, 8'hff, 1'b1, 1'b1, 1'b1}, 1'b1, PINS_RESET},
    '{'{OP_UNUSED_7, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, PINS_RESET},
    // start condition, with commands arriving while busy
    '{'{OP_START,    8'hff, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{'{OP_READ,     8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h5a, 1'b1, 1'b0, 1'b1}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'hff, 1'b1, 1'b1, 1'b1}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b1}, 1'b0, PINS_RESET},
    '{'{OP_STOP,     8'hff, 1'b0, 1'b1, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b1, 1'b1, 1'b1}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b1}, 1'b0, PINS_RESET},
    // ack wait: one high sample, then the slave pulls sda low
    '{'{OP_WAIT_ACK, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, PINS_RESET},
    '{'{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, PINS_RESET},
    // byte write, msb set so sda is released first; random ticks finish it
    '{'{OP_WRITE,    8'ha5, 1'b0, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}}
  };

  // sender gaps: none during burst stretches, else mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[9]) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // next beat: mostly well-formed sequences, with some noise mixed in
  function automatic cmd_beat_t pick_beat(input int p_high, input bit want_cmd);
    cmd_beat_t b;
    int r;
    b.op        = OP_TICK;
    b.data_byte = 8'($urandom);
    b.send_ack  = 1'($urandom);
    b.sda_level = 1'($urandom);
    b.scl_level = 1'($urandom);
    r = $urandom_range(0, 99);
    if (ph == PH_IDLE) begin
      if (want_cmd && r < 88) b.op = op_pool[$urandom_range(0, 4)];
      else if (r >= 94) b.op = op_pool[$urandom_range(5, 6)];
    end else begin
      // stray command while busy
      if (r < 6) b.op = op_pool[$urandom_range(0, 6)];
      // slave stretches the clock now and then
      if (ph == PH_RD_WAIT) b.scl_level = ($urandom_range(0, 99) < 60);
      if (ph == PH_WA_POLL) b.sda_level = ($urandom_range(0, 99) < p_high);
    end
    return b;
  endfunction

  // offer one beat, hold it until taken, then record what it should cause
  task automatic send_beat(input cmd_beat_t b, input logic typed, input pin_res_t typed_res);
    int gap;
    pin_res_t due;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= InDataW'({b.scl_level, b.sda_level, b.send_ack, b.data_byte});
    s_axis_tuser_i  <= b.op;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    due = step_sequencer(b);
    pins_due_q.push_back(typed ? typed_res : due);
    accepted_beats++;
  endtask

  // register write, enable lowered by the caller after the last one
  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_TICKS_PER_US) tpu = val;
    else ack_limit = val;
  endtask

  initial begin
    cmd_beat_t b;
    int cmds_left;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (dir_table[i]) send_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].res);

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        // block idle: every beat answered, then an idle margin before the register writes
        s_axis_tvalid_i <= 1'b0;
        while (pins_due_q.size() != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
        write_reg(CFG_TICKS_PER_US, 8'(plan_tpu[p]));
        write_reg(CFG_ACK_TIMEOUT, 8'(plan_ato[p]));
        cfg_we_i <= 1'b0;
      end
      // issue the planned commands, then keep ticking until the last one ends
      cmds_left = plan_cmds[p];
      while (cmds_left > 0 || ph != PH_IDLE) begin
        b = pick_beat(plan_high[p], cmds_left > 0);
        if (ph == PH_IDLE && b.op != OP_TICK && b.op <= OP_WAIT_ACK) cmds_left--;
        send_beat(b, 1'b0, PINS_RESET);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pins_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, burst stretches and one long hold-off
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && accepted_beats >= 60) begin
      // sender keeps offering so the block backs up and drops tready
      long_hold_done  <= 1'b1;
      hold_left       <= 300;
      m_axis_tready_i <= 1'b0;
    end else if (cycle_cnt[8] || $urandom_range(0, 99) < 70) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= 1'b0;
      hold_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every output beat against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic pin_res_t unpack_pins(input logic [OutDataW-1:0] d);
    pin_res_t r;
    r.scl_low = d[0];
    r.sda_low = d[1];
    r.busy    = d[2];
    r.done    = d[3];
    r.rd      = d[11:4];
    r.missing = d[12];
    return r;
  endfunction

  always @(posedge clk_i) begin
    pin_res_t got;
    pin_res_t want;
    bit bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = unpack_pins(m_axis_tdata_o);
      if (pins_due_q.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10)
          $display("unexpected output beat at cycle %0d: tdata %04h", cycle_cnt, m_axis_tdata_o);
      end else begin
        want = pins_due_q.pop_front();
        bad = (got.scl_low !== want.scl_low) || (got.sda_low !== want.sda_low) ||
              (got.busy !== want.busy) || (got.done !== want.done) ||
              (got.rd !== want.rd) || (got.missing !== want.missing);
        if (bad) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) begin
            $display("mismatch at cycle %0d: scl/sda/busy/done/rd/miss", cycle_cnt);
            $display("  expected %b %b %b %b %02h %b", want.scl_low, want.sda_low,
                     want.busy, want.done, want.rd, want.missing);
            $display("  actual   %b %b %b %b %02h %b", got.scl_low, got.sda_low,
                     got.busy, got.done, got.rd, got.missing);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/i2cbb_pkg.sv
src/i2cbb_front.sv
src/i2cbb_fifo.sv
src/i2cbb_seq.sv
src/i2c_bit_bang_master.sv
src/i2cbb_checker.sv
verif/testbench.sv
